// File: sv/ebmrw_pkg.sv
// ----------------------------------------------------------------------------
// ebmrw_pkg
// Types and constants of the ext2 block-map read walker.
// ----------------------------------------------------------------------------
package ebmrw_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_RESP  = 2'd2;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EOF     = 2'd2;

    localparam logic CFG_BS_LOG2 = 1'b0;
    localparam logic CFG_FSIZE   = 1'b1;

    localparam logic [16:0] WORD_BYTES = 17'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot;
        logic [31:0] word_value;
        logic [31:0] start_offset;
        logic [31:0] read_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [47:0] disk_address;
        logic [16:0] chunk_bytes;
        logic [1:0]  status;
        logic [31:0] reported_length;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_SLOTRD,
        S_DIRECT,
        S_WAIT
    } state_t;

endpackage

// File: sv/ebmrw_ram.sv
// ----------------------------------------------------------------------------
// ebmrw_ram
// Generic single-port-write RAM with one registered read port.
// ----------------------------------------------------------------------------
module ebmrw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ext2_block_map_read_walker.sv
// ----------------------------------------------------------------------------
// ext2_block_map_read_walker
// Maps a byte range of a file through the ext2 direct/indirect block tree,
// asks for pointer words and emits per-block data chunks.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        input      start & !busy       in_item  (in_item_t)
// out       output     result_valid strobe result   (out_item_t)
// cfg       input      cfg_valid&cfg_ready cfg_index, cfg_data
//
// A load or ignored item leaves the sequencer state as it is. A range read
// passes through step, slot RAM read and chunk for each direct block, plus a
// final step for the completion. An indirect block passes through the same
// states up to its first fetch; each response is taken in the wait state and
// yields its next fetch, its chunk or an end-of-file completion. Every result
// is registered before it leaves the block. busy is low only while idle or waiting for a
// response. Results are one-cycle strobes; the receiver cannot stall them.
// Reset clears all control state; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
module ext2_block_map_read_walker #(
    parameter int DIRECT_SLOTS  = 12,
    parameter int POINTER_SLOTS = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ebmrw_pkg::in_item_t  in_item,
    output logic                 result_valid,
    output ebmrw_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import ebmrw_pkg::*;

    localparam int SW = 4;

    logic [4:0]  bsl_reg;
    logic [31:0] fsize_reg;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] rlen_reg, rlen_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic [1:0]  stg_reg, stg_next;
    state_t      st_reg, st_next;
    logic        res_v_next;
    out_item_t   res_next;
    logic        res_v_reg;
    out_item_t   res_reg;

    logic            ram_we;
    logic [SW-1:0]   ram_ra, ram_ra_next, ram_ra_reg;
    logic [31:0]     ram_rd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg   <= 5'd10;
            fsize_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BS_LOG2: bsl_reg   <= cfg_data[4:0];
                CFG_FSIZE:   fsize_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic acc;
    assign acc = start && !busy;

    // Slot loads go straight to the RAM
    assign ram_we = acc && in_item.req_type == REQ_LOAD
                    && in_item.slot < SW'(POINTER_SLOTS);
    assign ram_ra = ram_ra_next;

    ebmrw_ram #(.WIDTH(32), .DEPTH(16)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_item.slot),
        .wdata (in_item.word_value),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    // Block geometry
    logic [4:0]  lg;
    logic [3:0]  p;
    logic [31:0] lb;
    logic [31:0] off;
    logic [31:0] bs;
    always_comb
    begin
        lg = (bsl_reg < 5'd10) ? 5'd10 : (bsl_reg > 5'd16) ? 5'd16 : bsl_reg;
        p  = 4'(lg - 5'd2);
        bs = 32'd1 << lg;
        lb = cur_reg >> lg;
        off = cur_reg & (bs - 32'd1);
    end

    // Map the current logical block to a level and word indices
    logic [1:0]  mlvl;
    logic [13:0] idx0, idx1, idx2, didx;
    logic [31:0] r1, r2;
    logic [33:0] m;
    always_comb
    begin
        m    = (34'd1 << p) - 34'd1;
        idx0 = '0;
        idx1 = '0;
        idx2 = '0;
        didx = lb[13:0];
        r1   = lb - 32'(DIRECT_SLOTS);
        r2   = r1 - (32'd1 << p);
        if (lb < 32'(DIRECT_SLOTS))
        begin
            mlvl = 2'd0;
        end
        else if ({2'b0, r1} < (34'd1 << p))
        begin
            mlvl = 2'd1;
            idx0 = r1[13:0];
        end
        else if ({2'b0, r2} < (34'd1 << (2 * p)))
        begin
            mlvl = 2'd2;
            idx0 = 14'((r2 >> p) & m[31:0]);
            idx1 = 14'(r2 & m[31:0]);
        end
        else
        begin
            mlvl = 2'd3;
            r2   = r2 - 32'((34'd1 << (2 * p)));
            idx0 = 14'((r2 >> (2 * p)) & m[31:0]);
            idx1 = 14'((r2 >> p) & m[31:0]);
            idx2 = 14'(r2 & m[31:0]);
        end
    end

    // Sequencer next state
    logic [13:0] sel_idx;
    logic [1:0]  nst;
    logic [31:0] chunk;
    logic [31:0] blk;
    logic        have_blk;
    always_comb
    begin
        st_next     = st_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        rlen_next   = rlen_reg;
        lvl_next    = lvl_reg;
        stg_next    = stg_reg;
        ram_ra_next = ram_ra_reg;
        res_v_next  = 1'b0;
        res_next    = '0;
        nst         = stg_reg + 2'd1;
        have_blk    = 1'b0;
        blk         = '0;
        chunk       = bs - off;
        if (chunk > left_reg)
        begin
            chunk = left_reg;
        end
        case (nst)
            2'd1:    sel_idx = idx1;
            default: sel_idx = idx2;
        endcase
        case (st_reg)
            S_IDLE:
            begin
                if (acc && in_item.req_type == REQ_START)
                begin
                    if ({1'b0, in_item.start_offset} + {1'b0, in_item.read_length}
                        > {1'b0, fsize_reg})
                    begin
                        res_v_next = 1'b1;
                        res_next.result_kind = KIND_DONE;
                        res_next.status = ST_INVALID;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        cur_next  = in_item.start_offset;
                        left_next = in_item.read_length;
                        rlen_next = in_item.read_length;
                        st_next   = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (left_reg == 32'd0)
                begin
                    res_v_next = 1'b1;
                    res_next.result_kind = KIND_DONE;
                    res_next.status = ST_OK;
                    res_next.reported_length = rlen_reg;
                    res_next.last = 1'b1;
                    lvl_next = '0;
                    stg_next = '0;
                    st_next  = S_IDLE;
                end
                else
                begin
                    lvl_next = mlvl;
                    stg_next = '0;
                    if (mlvl == 2'd0)
                    begin
                        ram_ra_next = SW'(didx);
                    end
                    else
                    begin
                        ram_ra_next = SW'(DIRECT_SLOTS + 32'(mlvl) - 1);
                    end
                    st_next = S_SLOTRD;
                end
            end
            S_SLOTRD:
            begin
                // RAM address registered last cycle; the read word is held for the direct state
                st_next = S_DIRECT;
            end
            S_DIRECT:
            begin
                if (lvl_reg == 2'd0)
                begin
                    have_blk = 1'b1;
                    blk = (ram_ra_reg < SW'(POINTER_SLOTS)) ? ram_rd : 32'd0;
                end
                else
                begin
                    blk = (32'(DIRECT_SLOTS) + 32'(lvl_reg) - 1 < 32'(POINTER_SLOTS))
                          ? ram_rd : 32'd0;
                    res_v_next = 1'b1;
                    res_next.result_kind = KIND_FETCH;
                    res_next.disk_address = (48'(blk) << lg) + (48'(idx0) << 2);
                    res_next.chunk_bytes = WORD_BYTES;
                    res_next.last = 1'b1;
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (acc && in_item.req_type == REQ_RESP)
                begin
                    if (nst < lvl_reg && nst != 2'd3)
                    begin
                        stg_next = nst;
                        res_v_next = 1'b1;
                        res_next.result_kind = KIND_FETCH;
                        res_next.disk_address = (48'(in_item.word_value) << lg)
                                                + (48'(sel_idx) << 2);
                        res_next.chunk_bytes = WORD_BYTES;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        lvl_next = '0;
                        stg_next = '0;
                        have_blk = 1'b1;
                        blk = in_item.word_value;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
        // Emit a chunk or end on a zero block
        if (have_blk)
        begin
            res_v_next = 1'b1;
            if (blk == 32'd0)
            begin
                res_next.result_kind = KIND_DONE;
                res_next.status = ST_EOF;
                res_next.reported_length = rlen_reg;
                res_next.last = 1'b1;
                lvl_next = '0;
                stg_next = '0;
                st_next  = S_IDLE;
            end
            else
            begin
                res_next.result_kind = KIND_CHUNK;
                res_next.disk_address = (48'(blk) << lg) + 48'(off);
                res_next.chunk_bytes = 17'(chunk);
                cur_next  = cur_reg + chunk;
                left_next = left_reg - chunk;
                st_next   = S_STEP;
            end
        end
    end

    // Hold state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            cur_reg    <= '0;
            left_reg   <= '0;
            rlen_reg   <= '0;
            lvl_reg    <= '0;
            stg_reg    <= '0;
            ram_ra_reg <= '0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            cur_reg    <= cur_next;
            left_reg   <= left_next;
            rlen_reg   <= rlen_next;
            lvl_reg    <= lvl_next;
            stg_reg    <= stg_next;
            ram_ra_reg <= ram_ra_next;
            res_v_reg  <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Loads are taken in any state that waits on outside input
    assign busy = !(st_reg == S_IDLE || st_reg == S_WAIT);
    assign result_valid = res_v_reg;
    assign result = res_reg;
endmodule

// File: verif/ebmrw_checker.sv
// ----------------------------------------------------------------------------
// ebmrw_checker
// Watches the item, result and register channels of the block-map read
// walker, predicts every result from the accepted items and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ebmrw_checker
    import ebmrw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    in_item,
    input  logic        result_valid,
    input  out_item_t   result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          err_count,
    output int          pending
);

    localparam int NUM_DIRECT = 12;
    localparam int NUM_PTRS   = 15;

    // shadow registers and walk state
    logic [4:0]  bs_log2;
    logic [31:0] fsize;
    logic [31:0] ptr_slot [NUM_PTRS];
    logic [31:0] cur_off;
    logic [31:0] left_bytes;
    logic [31:0] req_len;
    int          tree_lvl;
    int          tree_stage;
    bit          reading;

    out_item_t   expected_q [$];

    function automatic int lg_eff();
        if (bs_log2 < 5'd10) return 10;
        if (bs_log2 > 5'd16) return 16;
        return int'(bs_log2);
    endfunction

    function automatic logic [31:0] slot_word(logic [63:0] s);
        if (s < NUM_PTRS) return ptr_slot[s];
        return 32'd0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [63:0] addr,
                                        logic [63:0] nbytes, logic [1:0] st,
                                        logic [31:0] rlen, logic lst);
        out_item_t r;
        r.result_kind     = kind;
        r.disk_address    = addr[47:0];
        r.chunk_bytes     = nbytes[16:0];
        r.status          = st;
        r.reported_length = rlen;
        r.last            = lst;
        expected_q.push_back(r);
    endfunction

    // Split a logical block number into tree level and word indices.
    function automatic int tree_index(logic [63:0] lb, output logic [63:0] i0,
                                      output logic [63:0] i1, output logic [63:0] i2);
        int          p;
        logic [63:0] ptrs;
        logic [63:0] m;
        p    = lg_eff() - 2;
        ptrs = 64'd1 << p;
        m    = ptrs - 1;
        i0   = 0;
        i1   = 0;
        i2   = 0;
        if (lb < NUM_DIRECT)
        begin
            i0 = lb;
            return 0;
        end
        lb -= NUM_DIRECT;
        if (lb < ptrs)
        begin
            i0 = lb;
            return 1;
        end
        lb -= ptrs;
        if (lb < (ptrs << p))
        begin
            i0 = (lb >> p) & m;
            i1 = lb & m;
            return 2;
        end
        lb -= ptrs << p;
        i0 = (lb >> (2 * p)) & m;
        i1 = (lb >> p) & m;
        i2 = lb & m;
        return 3;
    endfunction

    function automatic void word_fetch(logic [31:0] blk, logic [63:0] index);
        push_result(KIND_FETCH, ({32'd0, blk} << lg_eff()) + index * 4,
                    64'(WORD_BYTES), ST_OK, 32'd0, 1'b1);
    endfunction

    function automatic void end_read(logic [1:0] st);
        reading    = 1'b0;
        tree_lvl   = 0;
        tree_stage = 0;
        push_result(KIND_DONE, 64'd0, 64'd0, st, req_len, 1'b1);
    endfunction

    // Emit the chunk of a mapped block, then walk on until a fetch or the end.
    function automatic void walk_on(bit have_blk, logic [31:0] blk);
        int          lg;
        int          lvl;
        logic [63:0] bsz;
        logic [63:0] off;
        logic [63:0] chunk;
        logic [63:0] i0, i1, i2;
        while (1)
        begin
            lg  = lg_eff();
            bsz = 64'd1 << lg;
            off = {32'd0, cur_off} & (bsz - 1);
            if (have_blk)
            begin
                if (blk == 32'd0)
                begin
                    end_read(ST_EOF);
                    return;
                end
                chunk = bsz - off;
                if (chunk > left_bytes)
                    chunk = {32'd0, left_bytes};
                push_result(KIND_CHUNK, ({32'd0, blk} << lg) + off, chunk,
                            ST_OK, 32'd0, 1'b0);
                cur_off    = cur_off + chunk[31:0];
                left_bytes = left_bytes - chunk[31:0];
                have_blk   = 1'b0;
                continue;
            end
            if (left_bytes == 32'd0)
            begin
                end_read(ST_OK);
                return;
            end
            lvl = tree_index({32'd0, cur_off} >> lg, i0, i1, i2);
            if (lvl == 0)
            begin
                blk      = slot_word(i0);
                have_blk = 1'b1;
                continue;
            end
            tree_lvl   = lvl;
            tree_stage = 0;
            word_fetch(slot_word(NUM_DIRECT + lvl - 1), i0);
            return;
        end
    endfunction

    function automatic void predict_item(in_item_t it);
        logic [63:0] i0, i1, i2;
        logic [63:0] pick;
        int          nxt;
        case (it.req_type)
            REQ_LOAD:
            begin
                if (it.slot < NUM_PTRS)
                    ptr_slot[it.slot] = it.word_value;
            end
            REQ_START:
            begin
                if (!reading)
                begin
                    if ({32'd0, it.start_offset} + {32'd0, it.read_length}
                        > {32'd0, fsize})
                        push_result(KIND_DONE, 64'd0, 64'd0, ST_INVALID, 32'd0, 1'b1);
                    else
                    begin
                        cur_off    = it.start_offset;
                        left_bytes = it.read_length;
                        req_len    = it.read_length;
                        reading    = 1'b1;
                        walk_on(1'b0, 32'd0);
                    end
                end
            end
            REQ_RESP:
            begin
                if (reading && tree_lvl != 0)
                begin
                    void'(tree_index({32'd0, cur_off} >> lg_eff(), i0, i1, i2));
                    nxt = tree_stage + 1;
                    if (nxt < tree_lvl && nxt < 3)
                    begin
                        tree_stage = nxt;
                        pick = (nxt == 1) ? i1 : i2;
                        word_fetch(it.word_value, pick);
                    end
                    else
                    begin
                        tree_lvl   = 0;
                        tree_stage = 0;
                        walk_on(1'b1, it.word_value);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Compare each result, field by field, with the oldest expectation; then track register writes and accepted items.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            bs_log2    = 5'd10;
            fsize      = 32'd0;
            cur_off    = 32'd0;
            left_bytes = 32'd0;
            req_len    = 32'd0;
            tree_lvl   = 0;
            tree_stage = 0;
            reading    = 1'b0;
            err_count  = 0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result %p", result);
                    err_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (result.result_kind !== e.result_kind)
                    begin
                        $error("result_kind exp %h got %h", e.result_kind, result.result_kind);
                        err_count++;
                    end
                    if (result.disk_address !== e.disk_address)
                    begin
                        $error("disk_address exp %h got %h", e.disk_address,
                               result.disk_address);
                        err_count++;
                    end
                    if (result.chunk_bytes !== e.chunk_bytes)
                    begin
                        $error("chunk_bytes exp %h got %h", e.chunk_bytes, result.chunk_bytes);
                        err_count++;
                    end
                    if (result.status !== e.status)
                    begin
                        $error("status exp %h got %h", e.status, result.status);
                        err_count++;
                    end
                    if (result.reported_length !== e.reported_length)
                    begin
                        $error("reported_length exp %h got %h", e.reported_length,
                               result.reported_length);
                        err_count++;
                    end
                    if (result.last !== e.last)
                    begin
                        $error("last exp %h got %h", e.last, result.last);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BS_LOG2)
                    bs_log2 = cfg_data[4:0];
                else
                    fsize = cfg_data;
            end
            if (start && !busy)
                predict_item(in_item);
            pending = expected_q.size();
        end
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives slot loads, range reads and pointer-word responses into the ext2
// block-map read walker, answers every fetch it asks for, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ebmrw_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE      = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    in_item = '0;
    logic        result_valid;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'd0;
    int          err_count;
    int          pending;

    int          fetch_seen = 0;
    int          done_seen = 0;
    int          fetch_used = 0;
    int          done_used = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          cur_lg = 10;
    bit          start_up = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ext2_block_map_read_walker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ebmrw_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .err_count    (err_count),
        .pending      (pending)
    );

    // Count fetch requests and completions so the walk can be answered.
    always @(posedge clk)
    begin
        if (result_valid && result.result_kind == KIND_FETCH)
            fetch_seen <= fetch_seen + 1;
        if (result_valid && result.result_kind == KIND_DONE)
            done_seen <= done_seen + 1;
    end

    // End the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic idle_cycle();
        if (start_up)
        begin
            start    <= 1'b0;
            start_up = 1'b0;
        end
        @(posedge clk);
    endtask

    // Offer one item after a random gap and hold it until accepted.
    task automatic send(in_item_t it);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) idle_cycle();
        start    <= 1'b1;
        start_up = 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic in_item_t noise_fields();
        in_item_t it;
        it.req_type     = REQ_LOAD;
        it.slot         = 4'($urandom);
        it.word_value   = $urandom;
        it.start_offset = $urandom;
        it.read_length  = $urandom;
        return it;
    endfunction

    task automatic load_slot(int s, logic [31:0] v);
        in_item_t it;
        it            = noise_fields();
        it.slot       = 4'(s);
        it.word_value = v;
        send(it);
    endtask

    task automatic send_noise(logic [1:0] kind);
        in_item_t it;
        it          = noise_fields();
        it.req_type = kind;
        if (kind == REQ_LOAD)
            it.word_value = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
        send(it);
    endtask

    // Wait for all expected results and let the block settle, then write.
    task automatic write_reg(logic idx, logic [31:0] val);
        idle_cycle();
        wait (pending == 0);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BS_LOG2)
            cur_lg = (val[4:0] < 10) ? 10 : (val[4:0] > 16) ? 16 : int'(val[4:0]);
    endtask

    // Start a range read and answer each pointer fetch until it completes.
    task automatic range_read(logic [31:0] off, logic [31:0] len);
        in_item_t it;
        int       pick;
        it              = noise_fields();
        it.req_type     = REQ_START;
        it.start_offset = off;
        it.read_length  = len;
        send(it);
        while (1)
        begin
            if (fetch_seen > fetch_used)
            begin
                fetch_used++;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_noise(REQ_LOAD);
                else if (pick == 1)
                    send_noise(REQ_START);
                else if (pick == 2)
                    send_noise(2'd3);
                it            = noise_fields();
                it.req_type   = REQ_RESP;
                it.word_value = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
                send(it);
            end
            else if (done_seen > done_used)
            begin
                done_used++;
                break;
            end
            else
                idle_cycle();
        end
    endtask

    task automatic random_read();
        logic [63:0] off;
        logic [63:0] blk;
        blk = 64'd1 << cur_lg;
        case ($urandom_range(0, 4))
            0: off = $urandom_range(0, 14 * (1 << cur_lg));
            1: off = 12 * blk + ((64'($urandom) * 64'($urandom_range(1, 2 ** 16)))
                     % ((blk / 4) * (blk / 4) + blk / 4));
            2: off = 12 * blk + (blk / 4) * blk - $urandom_range(0, 3000);
            3: off = 64'hFFFF_FFFF - $urandom_range(0, 3 * (1 << cur_lg));
            default: off = $urandom;
        endcase
        range_read(off[31:0], $urandom_range(0, 3 * (1 << cur_lg)));
    endtask

    initial
    begin
        logic [31:0] v;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill every slot, then walk every tree level
        write_reg(CFG_BS_LOG2, 32'd10);
        write_reg(CFG_FSIZE, 32'hFFFF_FFFF);
        for (int s = 0; s < 15; s++)
            load_slot(s, (s == 3) ? 32'd0 : $urandom | 32'd1);
        send_noise(REQ_RESP);
        send_noise(2'd3);
        load_slot(15, 32'hFFFF_FFFF);
        range_read(32'd0, 32'd0);
        range_read(32'd0, 32'd100);
        range_read(32'd1000, 32'd2048);
        range_read(32'd3 * 1024, 32'd10);
        range_read(32'hFFFF_FFFF, 32'd2);
        range_read(32'd12 * 1024, 32'd50);
        range_read(32'd12 * 1024 + 32'd256 * 1024, 32'd1500);
        range_read(32'd12 * 1024 + 32'd256 * 1024 + 32'd65536 * 1024, 32'd2100);
        range_read(32'hFFFF_FC00, 32'd1024);
        load_slot(0, 32'd0);
        range_read(32'd0, 32'hFFFF_FFFF);
        load_slot(0, 32'hFFFF_FFFF);
        write_reg(CFG_BS_LOG2, {27'h7FF_FFFF, 5'd16});
        range_read(32'd0, 32'd65536);
        range_read(32'd12 * 65536 + 7, 32'd70000);

        // random phases, each with new register values
        while (items_sent < 400)
        begin
            case ($urandom_range(0, 5))
                0: v = {$urandom, 5'd0} | 32'($urandom_range(0, 9));
                1: v = {$urandom, 5'd0} | 32'($urandom_range(17, 31));
                default: v = {$urandom, 5'd0} | 32'($urandom_range(10, 16));
            endcase
            write_reg(CFG_BS_LOG2, v);
            write_reg(CFG_FSIZE, ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFF_FFFF);
            for (int n = 0; n < 12; n++)
            begin
                case ($urandom_range(0, 9))
                    0: load_slot($urandom_range(0, 14), $urandom | 32'd1);
                    1: send_noise($urandom_range(0, 1) ? REQ_RESP : 2'd3);
                    default: random_read();
                endcase
            end
        end

        idle_cycle();
        wait (pending == 0);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
